>>> rtl/core/gcd_pkg.sv
// Shared constants, tables and types of the great-circle distance pipeline.
package gcd_pkg;

  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int DIST_W = 25;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int CORDIC_MAX = 32;
  localparam int CW = 34;
  localparam int LANES_ROT = 4;

  // Angle conversion: inputs are offset by 45 * 2^24 so the divide by 45 is unsigned.
  localparam int ANG_W = 32;
  localparam int X_W = 30;
  localparam int U_W = 31;
  localparam int DIV45 = 45;
  localparam int DIV45_SH = 37;
  localparam int DIV45_MW = 32;
  localparam int P45_W = U_W + DIV45_MW;
  localparam int Q_W = P45_W - DIV45_SH;
  localparam int B_W = 6;
  localparam int V_W = 16;
  localparam int DIV90_SH = 23;
  localparam int DIV90_MW = 17;
  localparam int P90_W = V_W + DIV90_MW;
  localparam int T_W = P90_W - DIV90_SH;
  localparam logic [U_W-1:0] ANG_OFF = U_W'(45 * (64'd1 << 24));
  localparam logic [DIV45_MW-1:0] DIV45_MUL =
    DIV45_MW'(((64'd1 << DIV45_SH) + 64'd44) / 64'd45);
  localparam logic [DIV90_MW-1:0] DIV90_MUL =
    DIV90_MW'(((64'd1 << DIV90_SH) + 64'd89) / 64'd90);
  localparam logic [V_W-1:0] HALF_90 = V_W'(45);

  localparam logic [CW-1:0] GAIN_INV = CW'(652032874);
  localparam logic [CW-1:0] ONE30 = CW'(64'd1 << 30);

  localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  localparam int SQRT_BITS = 31;
  localparam int SQRT_W = 62;
  localparam int A_W = 31;

  localparam logic [63:0] DIST_SCALE = 64'd5123862220;
  localparam int DIST_LO_W = 17;
  localparam int DIST_HI_W = 16;
  localparam logic [DIST_LO_W-1:0] DIST_LO = DIST_LO_W'(DIST_SCALE);
  localparam logic [DIST_HI_W-1:0] DIST_HI = DIST_HI_W'(DIST_SCALE >> DIST_LO_W);
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(20015087);

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [SQRT_W-1:0]    rem;
    logic [SQRT_BITS-1:0] root;
  } sqrt_t;

endpackage

>>> rtl/core/gcd_if.sv
// Channel interfaces of the great-circle distance block: point pairs in, distances out.
interface gcd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [gcd_pkg::LAT_W-1:0] first_latitude;
  logic signed [gcd_pkg::LON_W-1:0] first_longitude;
  logic signed [gcd_pkg::LAT_W-1:0] second_latitude;
  logic signed [gcd_pkg::LON_W-1:0] second_longitude;

  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface gcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcd_pkg::DIST_W-1:0]  distance_meters;

  modport source (output valid, distance_meters, input ready);
  modport sink (input valid, distance_meters, output ready);
endinterface

>>> rtl/core/gcd_angle.sv
// Conversion of coordinates to folded binary angles for the four rotation lanes.
module gcd_angle (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic signed [gcd_pkg::LAT_W-1:0] first_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0] first_longitude_i,
  input  logic signed [gcd_pkg::LAT_W-1:0] second_latitude_i,
  input  logic signed [gcd_pkg::LON_W-1:0] second_longitude_i,
  output logic                             vld_o,
  output logic [gcd_pkg::CW-1:0]           z_o [gcd_pkg::LANES_ROT],
  output logic [gcd_pkg::LANES_ROT-1:0]    neg_o
);

  localparam int NL = gcd_pkg::LANES_ROT;

  logic signed [gcd_pkg::ANG_W-1:0] x_s [NL];
  logic [5:0]                       vld_q;
  logic [gcd_pkg::U_W-1:0]          u0_q [NL];
  logic [gcd_pkg::U_W-1:0]          u1_q [NL];
  logic [gcd_pkg::P45_W-1:0]        p45_q [NL];
  logic [gcd_pkg::Q_W-1:0]          q2_q [NL];
  logic [gcd_pkg::B_W-1:0]          b2_q [NL];
  logic [gcd_pkg::Q_W-1:0]          q3_q [NL];
  logic [gcd_pkg::P90_W-1:0]        p90_q [NL];
  logic [gcd_pkg::ANG_W-1:0]        ang_q [NL];
  logic [gcd_pkg::CW-1:0]           z_q [NL];
  logic [NL-1:0]                    neg_q;

  // Lanes 0 and 1 are the two latitudes, lanes 2 and 3 the half differences.
  always_comb begin
    x_s[0] = gcd_pkg::ANG_W'(first_latitude_i);
    x_s[1] = gcd_pkg::ANG_W'(second_latitude_i);
    x_s[2] = gcd_pkg::ANG_W'(second_latitude_i) - gcd_pkg::ANG_W'(first_latitude_i);
    x_s[3] = gcd_pkg::ANG_W'(second_longitude_i) - gcd_pkg::ANG_W'(first_longitude_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NL; l++) begin
        u0_q[l]  <= gcd_pkg::U_W'(x_s[l] + gcd_pkg::ANG_W'(gcd_pkg::ANG_OFF));
        p45_q[l] <= gcd_pkg::P45_W'(u0_q[l]) * gcd_pkg::P45_W'(gcd_pkg::DIV45_MUL);
        u1_q[l]  <= u0_q[l];
        q2_q[l]  <= p45_q[l][gcd_pkg::P45_W-1:gcd_pkg::DIV45_SH];
        b2_q[l]  <= gcd_pkg::B_W'(u1_q[l] - gcd_pkg::U_W'(p45_q[l][gcd_pkg::P45_W-1:
                     gcd_pkg::DIV45_SH]) * gcd_pkg::U_W'(gcd_pkg::DIV45));
        q3_q[l]  <= q2_q[l];
        // The remainder picks the rounded fraction of the quotient by 90.
        if (l < 2) begin
          p90_q[l] <= gcd_pkg::P90_W'((gcd_pkg::V_W'(b2_q[l]) << 10) + gcd_pkg::HALF_90) *
                      gcd_pkg::P90_W'(gcd_pkg::DIV90_MUL);
          ang_q[l] <= (gcd_pkg::ANG_W'(q3_q[l]) << 9) +
                      gcd_pkg::ANG_W'(p90_q[l][gcd_pkg::P90_W-1:gcd_pkg::DIV90_SH]);
        end else begin
          p90_q[l] <= gcd_pkg::P90_W'((gcd_pkg::V_W'(b2_q[l]) << 9) + gcd_pkg::HALF_90) *
                      gcd_pkg::P90_W'(gcd_pkg::DIV90_MUL);
          ang_q[l] <= (gcd_pkg::ANG_W'(q3_q[l]) << 8) +
                      gcd_pkg::ANG_W'(p90_q[l][gcd_pkg::P90_W-1:gcd_pkg::DIV90_SH]);
        end
        // The input offset scaled by 512 or 256 is a multiple of a full turn and drops out.
        if ($signed(gcd_pkg::CW'($signed(ang_q[l]))) > $signed(gcd_pkg::ONE30)) begin
          z_q[l]   <= gcd_pkg::CW'($signed(ang_q[l])) - (gcd_pkg::ONE30 << 1);
          neg_q[l] <= 1'b1;
        end else if ($signed(gcd_pkg::CW'($signed(ang_q[l]))) < -$signed(gcd_pkg::ONE30)) begin
          z_q[l]   <= gcd_pkg::CW'($signed(ang_q[l])) + (gcd_pkg::ONE30 << 1);
          neg_q[l] <= 1'b1;
        end else begin
          z_q[l]   <= gcd_pkg::CW'($signed(ang_q[l]));
          neg_q[l] <= 1'b0;
        end
      end
    end
  end

  assign vld_o = vld_q[5];
  assign z_o   = z_q;
  assign neg_o = neg_q;

endmodule

>>> rtl/core/gcd_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, over a few lanes.
module gcd_cordic_cell #(
  parameter int STAGE     = 0,
  parameter int LANES     = 1,
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W    = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  gcd_pkg::cord_t        lane_i [LANES],
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  output gcd_pkg::cord_t        lane_o [LANES],
  output logic [SIDE_W-1:0]     side_o
);

  localparam logic [gcd_pkg::CW-1:0] ATAN = gcd_pkg::CW'(gcd_pkg::ATAN_TAB[STAGE]);

  gcd_pkg::cord_t    lane_d [LANES];
  gcd_pkg::cord_t    lane_q [LANES];
  logic              vld_q;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    logic [gcd_pkg::CW-1:0] xs;
    logic [gcd_pkg::CW-1:0] ys;
    logic                   pos;
    for (int l = 0; l < LANES; l++) begin
      xs = gcd_pkg::CW'($signed(lane_i[l].x) >>> STAGE);
      ys = gcd_pkg::CW'($signed(lane_i[l].y) >>> STAGE);
      // Rotation drives z to zero, vectoring drives y to zero.
      pos = VECTORING ? lane_i[l].y[gcd_pkg::CW-1] : ~lane_i[l].z[gcd_pkg::CW-1];
      if (pos) begin
        lane_d[l].x = lane_i[l].x - ys;
        lane_d[l].y = lane_i[l].y + xs;
        lane_d[l].z = lane_i[l].z - ATAN;
      end else begin
        lane_d[l].x = lane_i[l].x + ys;
        lane_d[l].y = lane_i[l].y - xs;
        lane_d[l].z = lane_i[l].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;
  assign side_o = side_q;

endmodule

>>> rtl/core/gcd_sqrt_cell.sv
// One digit cell of the integer square root: decides a single root bit per lane.
module gcd_sqrt_cell #(
  parameter int BIT   = 0,
  parameter int LANES = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  gcd_pkg::sqrt_t lane_i [LANES],
  output logic           vld_o,
  output gcd_pkg::sqrt_t lane_o [LANES]
);

  gcd_pkg::sqrt_t lane_d [LANES];
  gcd_pkg::sqrt_t lane_q [LANES];
  logic           vld_q;

  // Setting this bit grows the square by 2^(BIT+1) * root + 2^(2*BIT).
  always_comb begin
    logic [gcd_pkg::SQRT_W-1:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = (gcd_pkg::SQRT_W'(lane_i[l].root) << (BIT + 1)) +
              (gcd_pkg::SQRT_W'(1) << (2 * BIT));
      lane_d[l] = lane_i[l];
      if (lane_i[l].rem >= trial) begin
        lane_d[l].rem       = lane_i[l].rem - trial;
        lane_d[l].root[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

>>> rtl/core/great_circle_distance.sv
// Top level: haversine distance pipeline built from chains of CORDIC and square-root cells.
//
// Each word on in_i carries two points, latitude and longitude in degrees times 2^20.
// Each word on out_o carries the great-circle distance on a 6371 km sphere in whole
// meters, saturated at 20015087. Both channels are valid/ready; a word moves at a
// rising edge where valid and ready are both high.
//
// The datapath is fully pipelined: one word is accepted in every cycle while the
// receiver does not stall. A result passes through the angle conversion registers,
// one chain of CORDIC_STAGES rotation cells, the product registers, a chain of 31
// square-root cells, one chain of CORDIC_STAGES vectoring cells, the scaling
// registers and the output register.
//
// When the receiver stalls, the output register holds its word and the pipeline keeps
// moving until one more finished word lands in a skid register; only then does in_i
// drop ready and the whole pipeline freeze. Reset empties every stage; there is no
// other state.
module great_circle_distance #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gcd_in_if.sink           in_i,
  gcd_out_if.source        out_o
);

  localparam int NL = gcd_pkg::LANES_ROT;
  localparam int SB = gcd_pkg::SQRT_BITS;

  logic en;
  logic acc;

  logic                   ang_vld;
  logic [gcd_pkg::CW-1:0] ang_z [NL];
  logic [NL-1:0]          ang_neg;

  gcd_pkg::cord_t rot_lane [CORDIC_STAGES+1][NL];
  logic           rot_vld  [CORDIC_STAGES+1];
  logic [NL-1:0]  rot_side [CORDIC_STAGES+1];

  logic [5:0]        pv_q;
  logic signed [31:0] c1_q, c2_q, sh_q, sl_q;
  logic signed [63:0] sh2p_q, ccp_q, sl2p_q;
  logic signed [31:0] sh2_q, cc_q, sl2_q, sh2b_q;
  logic signed [63:0] mp_q;
  logic [gcd_pkg::A_W-1:0]    a_q;
  logic [gcd_pkg::SQRT_W-1:0] va_q, vt_q;
  logic signed [33:0]         asum;

  gcd_pkg::sqrt_t sq_lane [SB+1][2];
  logic           sq_vld  [SB+1];

  gcd_pkg::cord_t vec_lane [CORDIC_STAGES+1][1];
  logic           vec_vld  [CORDIC_STAGES+1];
  logic           vec_side [CORDIC_STAGES+1];

  logic [2:0]                      dv_q;
  logic [31:0]                     zc_q;
  logic [31+gcd_pkg::DIST_LO_W:0]  pl_q;
  logic [31+gcd_pkg::DIST_HI_W:0]  ph_q;
  logic [65:0]                     dsum;
  logic [27:0]                     dd;
  logic [gcd_pkg::DIST_W-1:0]      fin_q;

  logic                       out_vld_q;
  logic [gcd_pkg::DIST_W-1:0] out_q;
  logic                       skid_vld_q;
  logic [gcd_pkg::DIST_W-1:0] skid_q;

  function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd536870912) >>> 30;
    return 32'(s);
  endfunction

  assign en         = ~skid_vld_q;
  assign in_i.ready = en;
  assign acc        = in_i.valid & en;

  gcd_angle u_angle (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_i               (en),
    .vld_i              (acc),
    .first_latitude_i   (in_i.first_latitude),
    .first_longitude_i  (in_i.first_longitude),
    .second_latitude_i  (in_i.second_latitude),
    .second_longitude_i (in_i.second_longitude),
    .vld_o              (ang_vld),
    .z_o                (ang_z),
    .neg_o              (ang_neg)
  );

  // Rotation chain: cosines of both latitudes, sines of both half differences.
  assign rot_vld[0]  = ang_vld;
  assign rot_side[0] = ang_neg;
  for (genvar l = 0; l < NL; l++) begin : g_rot_in
    assign rot_lane[0][l] = '{x: gcd_pkg::GAIN_INV, y: '0, z: ang_z[l]};
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
    gcd_cordic_cell #(
      .STAGE     (g),
      .LANES     (NL),
      .VECTORING (1'b0),
      .SIDE_W    (NL)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (rot_vld[g]),
      .lane_i (rot_lane[g]),
      .side_i (rot_side[g]),
      .vld_o  (rot_vld[g+1]),
      .lane_o (rot_lane[g+1]),
      .side_o (rot_side[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[4:0], rot_vld[CORDIC_STAGES]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q <= rot_side[CORDIC_STAGES][0] ? -32'($signed(rot_lane[CORDIC_STAGES][0].x))
                                         : 32'($signed(rot_lane[CORDIC_STAGES][0].x));
      c2_q <= rot_side[CORDIC_STAGES][1] ? -32'($signed(rot_lane[CORDIC_STAGES][1].x))
                                         : 32'($signed(rot_lane[CORDIC_STAGES][1].x));
      sh_q <= rot_side[CORDIC_STAGES][2] ? -32'($signed(rot_lane[CORDIC_STAGES][2].y))
                                         : 32'($signed(rot_lane[CORDIC_STAGES][2].y));
      sl_q <= rot_side[CORDIC_STAGES][3] ? -32'($signed(rot_lane[CORDIC_STAGES][3].y))
                                         : 32'($signed(rot_lane[CORDIC_STAGES][3].y));
      sh2p_q <= sh_q * sh_q;
      ccp_q  <= c1_q * c2_q;
      sl2p_q <= sl_q * sl_q;
      sh2_q  <= rnd30(sh2p_q);
      cc_q   <= rnd30(ccp_q);
      sl2_q  <= rnd30(sl2p_q);
      mp_q   <= cc_q * sl2_q;
      sh2b_q <= sh2_q;
      if (asum < 0) begin
        a_q <= '0;
      end else if (asum > 34'sd1073741824) begin
        a_q <= gcd_pkg::A_W'(gcd_pkg::ONE30);
      end else begin
        a_q <= gcd_pkg::A_W'(asum);
      end
      va_q <= gcd_pkg::SQRT_W'({a_q, 30'b0});
      vt_q <= gcd_pkg::SQRT_W'({gcd_pkg::A_W'(gcd_pkg::ONE30) - a_q, 30'b0});
    end
  end

  assign asum = 34'(sh2b_q) + 34'(rnd30(mp_q));

  // Square-root chain: lane 0 gives sqrt(a), lane 1 gives sqrt(1 - a).
  assign sq_vld[0]  = pv_q[5];
  assign sq_lane[0][0] = '{rem: va_q, root: '0};
  assign sq_lane[0][1] = '{rem: vt_q, root: '0};

  for (genvar g = 0; g < SB; g++) begin : g_sqrt
    gcd_sqrt_cell #(
      .BIT   (SB - 1 - g),
      .LANES (2)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[g]),
      .lane_i (sq_lane[g]),
      .vld_o  (sq_vld[g+1]),
      .lane_o (sq_lane[g+1])
    );
  end

  // Vectoring chain: the accumulated angle is half the central angle.
  assign vec_vld[0]     = sq_vld[SB];
  assign vec_side[0]    = 1'b0;
  assign vec_lane[0][0] = '{x: gcd_pkg::CW'(sq_lane[SB][1].root),
                            y: gcd_pkg::CW'(sq_lane[SB][0].root), z: '0};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    gcd_cordic_cell #(
      .STAGE     (g),
      .LANES     (1),
      .VECTORING (1'b1),
      .SIDE_W    (1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vec_vld[g]),
      .lane_i (vec_lane[g]),
      .side_i (vec_side[g]),
      .vld_o  (vec_vld[g+1]),
      .lane_o (vec_lane[g+1]),
      .side_o (vec_side[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= {dv_q[1:0], vec_vld[CORDIC_STAGES]};
    end
  end

  // The distance constant is split so that each partial product stays narrow.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vec_lane[CORDIC_STAGES][0].z[gcd_pkg::CW-1]) begin
        zc_q <= '0;
      end else if ($signed(vec_lane[CORDIC_STAGES][0].z) > $signed(gcd_pkg::ONE30 << 1)) begin
        zc_q <= 32'h8000_0000;
      end else begin
        zc_q <= 32'(vec_lane[CORDIC_STAGES][0].z);
      end
      pl_q  <= (32 + gcd_pkg::DIST_LO_W)'(zc_q) * (32 + gcd_pkg::DIST_LO_W)'(gcd_pkg::DIST_LO);
      ph_q  <= (32 + gcd_pkg::DIST_HI_W)'(zc_q) * (32 + gcd_pkg::DIST_HI_W)'(gcd_pkg::DIST_HI);
      fin_q <= (dd > 28'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : gcd_pkg::DIST_W'(dd);
    end
  end

  assign dsum = (66'(ph_q) << gcd_pkg::DIST_LO_W) + 66'(pl_q) + (66'(1) << 37);
  assign dd   = dsum[65:38];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !out_o.ready) begin
      if (en && dv_q[2]) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !out_o.ready) begin
      if (en && dv_q[2]) begin
        skid_q <= fin_q;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else if (dv_q[2]) begin
      out_q <= fin_q;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.distance_meters = out_q;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register is empty");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q <= gcd_pkg::DIST_MAX))
    else $error("distance beyond saturation limit");

  a_a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q[4] |-> (a_q <= gcd_pkg::A_W'(gcd_pkg::ONE30)))
    else $error("haversine term not clamped to one");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_q))
    else $error("pipeline advanced while frozen");
`endif

endmodule

>>> test/great_circle_distance_tb.sv
// Self-checking testbench of the great-circle distance pipeline.
`timescale 1ns / 100ps

module great_circle_distance_tb;

  localparam int STAGES = gcd_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY = 47 + 2 * STAGES;
  localparam int RANDOM_PAIRS = 500;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint UNIT = 64'sd1 << 30;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;

  typedef struct {
    logic signed [gcd_pkg::LAT_W-1:0] lat1;
    logic signed [gcd_pkg::LON_W-1:0] lon1;
    logic signed [gcd_pkg::LAT_W-1:0] lat2;
    logic signed [gcd_pkg::LON_W-1:0] lon2;
    bit                               known;
    logic [gcd_pkg::DIST_W-1:0]       meters;
  } pair_row_t;

  logic clk_i;
  logic rst_ni;
  gcd_in_if  in_bus ();
  gcd_out_if out_bus ();

  great_circle_distance #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  logic [gcd_pkg::DIST_W-1:0] pending_dist[$];
  int errors = 0;
  int cycles = 0;
  int words_in = 0;
  int words_out = 0;
  bit calm = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Binary angle from degrees * 2^20: round(num / den) with ties upward.
  function automatic logic [31:0] to_turns(longint num, longint den);
    longint n, d, q;
    n = 2 * num + den;
    d = 2 * den;
    if (n >= 0) q = n / d;
    else q = -((-n + d - 1) / d);
    return q[31:0];
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > UNIT) begin
      z -= 2 * UNIT;
      flip = 1;
    end else if (z < -UNIT) begin
      z += 2 * UNIT;
      flip = 1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(gcd_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(gcd_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b + (UNIT >>> 1)) >>> 30;
  endfunction

  function automatic longint root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] sphere_dist(pair_row_t p);
    longint la1, lo1, la2, lo2, s1, c1, s2, c2, sh, ch, sl, cl, a, s, t, x, y, z, nx;
    logic [63:0] d;
    la1 = longint'(p.lat1); lo1 = longint'(p.lon1);
    la2 = longint'(p.lat2); lo2 = longint'(p.lon2);
    rotate(to_turns(la1 * 512, 45), s1, c1);
    rotate(to_turns(la2 * 512, 45), s2, c2);
    rotate(to_turns((la2 - la1) * 256, 45), sh, ch);
    rotate(to_turns((lo2 - lo1) * 256, 45), sl, cl);
    a = fmul(sh, sh) + fmul(fmul(c1, c2), fmul(sl, sl));
    if (a < 0) a = 0;
    if (a > UNIT) a = UNIT;
    s = root_floor(64'(a) << 30);
    t = root_floor(64'(UNIT - a) << 30);
    x = t; y = s; z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(gcd_pkg::ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(gcd_pkg::ATAN_TAB[i]);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > 2 * UNIT) z = 2 * UNIT;
    d = (64'(z) * gcd_pkg::DIST_SCALE + (64'd1 << 37)) >> 38;
    if (d > 64'(gcd_pkg::DIST_MAX)) d = 64'(gcd_pkg::DIST_MAX);
    return d[gcd_pkg::DIST_W-1:0];
  endfunction

  function automatic longint pick(longint lim);
    return longint'($urandom_range(32'(2 * lim))) - lim;
  endfunction

  function automatic pair_row_t random_pair();
    pair_row_t p;
    int kind;
    kind = $urandom_range(9);
    p.known = 0;
    p.meters = '0;
    if (kind == 0) begin
      // Raw bits over the whole field width, coordinates that wrap.
      p.lat1 = gcd_pkg::LAT_W'($urandom()); p.lon1 = gcd_pkg::LON_W'($urandom());
      p.lat2 = gcd_pkg::LAT_W'($urandom()); p.lon2 = gcd_pkg::LON_W'($urandom());
    end else begin
      p.lat1 = gcd_pkg::LAT_W'(pick(LAT_MAX));
      p.lon1 = gcd_pkg::LON_W'(pick(LON_MAX));
      if (kind <= 3) begin
        // Nearby points exercise the small-angle end of the square roots.
        p.lat2 = gcd_pkg::LAT_W'(longint'(p.lat1) + pick(longint'($urandom_range(1 << 16))));
        p.lon2 = gcd_pkg::LON_W'(longint'(p.lon1) + pick(longint'($urandom_range(1 << 16))));
      end else if (kind == 4) begin
        // Close to the antipode.
        p.lat2 = gcd_pkg::LAT_W'(-longint'(p.lat1) + pick(4096));
        p.lon2 = gcd_pkg::LON_W'(longint'(p.lon1) + LON_MAX + pick(4096));
      end else begin
        p.lat2 = gcd_pkg::LAT_W'(pick(LAT_MAX));
        p.lon2 = gcd_pkg::LON_W'(pick(LON_MAX));
      end
    end
    return p;
  endfunction

  task automatic send_pair(pair_row_t p);
    int gap;
    gap = calm ? 0 : $urandom_range(10);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.first_latitude <= p.lat1;
    in_bus.first_longitude <= p.lon1;
    in_bus.second_latitude <= p.lat2;
    in_bus.second_longitude <= p.lon2;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_dist.push_back(p.known ? p.meters : sphere_dist(p));
    words_in++;
  endtask

  // Receiver: a random stall before each word, none while calm.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(10);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      words_out++;
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected distance word, actual %0d", $time, out_bus.distance_meters);
        errors++;
      end else begin
        if (out_bus.distance_meters !== pending_dist[0]) begin
          $display("%0t: distance mismatch, expected %0d, actual %0d",
                   $time, pending_dist[0], out_bus.distance_meters);
          errors++;
        end
        void'(pending_dist.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d distances outstanding", $time, pending_dist.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  pair_row_t plan[$];

  task automatic add_row(longint a1, longint o1, longint a2, longint o2);
    pair_row_t p;
    p.lat1 = gcd_pkg::LAT_W'(a1); p.lon1 = gcd_pkg::LON_W'(o1);
    p.lat2 = gcd_pkg::LAT_W'(a2); p.lon2 = gcd_pkg::LON_W'(o2);
    p.known = 0;
    p.meters = '0;
    plan.push_back(p);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.first_latitude = '0;
    in_bus.first_longitude = '0;
    in_bus.second_latitude = '0;
    in_bus.second_longitude = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(0, 0, 0, 0);
    add_row(LAT_MAX, 0, -LAT_MAX, 0);
    add_row(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    add_row(0, 0, 0, LON_MAX);
    add_row(0, -LON_MAX, 0, LON_MAX);
    add_row(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    add_row(0, 0, 1, 0);
    add_row(0, 0, 0, 1);
    add_row(12345678, -9876543, -12345678, -9876543 + LON_MAX);
    add_row(47185920, 0, -47185920, LON_MAX);
    // Coordinates beyond the nominal range wrap as plain angles.
    add_row(134217727, 268435455, -134217728, -268435456);
    add_row(-134217728, -268435456, 134217727, 268435455);
    add_row(LAT_MAX + 1000, LON_MAX + 1000, -LAT_MAX - 1000, -LON_MAX - 1000);
    add_row(-1, -1, 1, 1);
    add_row(LAT_MAX, 0, LAT_MAX, 100000);
    add_row(30000000, 60000000, 30000500, 60000500);
    foreach (plan[i]) send_pair(plan[i]);

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      calm = (n >= 150 && n < 220);
      if (n == 250) begin
        // Let the pipeline drain completely before carrying on.
        in_bus.valid <= 1'b0;
        while (pending_dist.size() != 0) @(posedge clk_i);
      end
      send_pair(random_pair());
    end
    in_bus.valid <= 1'b0;
    calm = 0;

    while (pending_dist.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Sent %0d point pairs (%0d directed), received %0d distances.",
             words_in, plan.size(), words_out);
    $display("Covered poles, antipodes, the date line, wrapped coordinates and random pairs.");
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
